>>> hw/rtl/tad_pkg.sv
package tad_pkg;

  // Field widths
  localparam int unsigned TempW  = 12;
  localparam int unsigned RateW  = 32;
  localparam int unsigned FreqW  = 12;
  localparam int unsigned VoltW  = 12;
  localparam int unsigned PowerW = 20;
  localparam int unsigned CountW = 8;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  // Outcome codes
  localparam logic [2:0] OUT_NONE     = 3'd0;
  localparam logic [2:0] OUT_ADJUST   = 3'd1;
  localparam logic [2:0] OUT_INVALID  = 3'd2;
  localparam logic [2:0] OUT_WARMUP   = 3'd3;
  localparam logic [2:0] OUT_TOO_SOON = 3'd4;
  localparam logic [2:0] OUT_RESET    = 3'd5;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CFG_TARGET_TEMP    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_FREQ_HI        = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FREQ_LO        = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_VOLT_HI        = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_VOLT_LO        = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_POWER_CAP      = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_WARMUP_SECONDS = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_LOW_RATE_LIMIT = 3'd7;

  // Register reset values
  localparam logic [7:0]        RST_TARGET_TEMP    = 8'd60;
  localparam logic [FreqW-1:0]  RST_FREQ_HI        = 12'd800;
  localparam logic [FreqW-1:0]  RST_FREQ_LO        = 12'd400;
  localparam logic [VoltW-1:0]  RST_VOLT_HI        = 12'd1400;
  localparam logic [VoltW-1:0]  RST_VOLT_LO        = 12'd1000;
  localparam logic [PowerW-1:0] RST_POWER_CAP      = 20'd40000;
  localparam logic [15:0]       RST_WARMUP_SECONDS = 16'd300;
  localparam logic [CountW-1:0] RST_LOW_RATE_LIMIT = 8'd3;

  // Decision constants
  localparam logic [7:0]       TEMP_INVALID_INT = 8'hFF;
  localparam logic [TempW-1:0] HOT_INTERVAL_Q   = 12'd1088;   // 68.0 C in Q8.4
  localparam logic [TimeW-1:0] INTERVAL_HOT_MS  = 32'd500;
  localparam logic [TimeW-1:0] INTERVAL_COOL_MS = 32'd300000;
  localparam logic signed [9:0] BAND_HALF       = 10'sd2;
  localparam logic [VoltW:0]   VOLT_BUMP_MV     = 13'd10;

  typedef struct packed {
    logic [TempW-1:0]  die_temp;
    logic [RateW-1:0]  current_rate;
    logic [RateW-1:0]  target_rate;
    logic [TimeW-1:0]  uptime;
    logic [FreqW-1:0]  freq_now;
    logic [VoltW-1:0]  volt_now;
    logic [PowerW-1:0] power_now;
    logic [CountW-1:0] low_rate_count;
    logic [TimeW-1:0]  elapsed_ms;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       outcome;
    logic [FreqW-1:0] freq_set;
    logic [VoltW-1:0] new_voltage;
  } out_item_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] value;
  } cfg_wr_t;

  typedef struct packed {
    logic [7:0]        target_temp;
    logic [FreqW-1:0]  freq_hi;
    logic [FreqW-1:0]  freq_lo;
    logic [VoltW-1:0]  volt_hi;
    logic [VoltW-1:0]  volt_lo;
    logic [PowerW-1:0] power_cap;
    logic [15:0]       warmup_seconds;
    logic [CountW-1:0] low_rate_limit;
  } cfg_regs_t;

  // floor(x/50) for x < 4200: x*1311 >> 16, exact over that range
  function automatic logic [6:0] div50(input logic [12:0] x);
    logic [23:0] p;
    p = {11'd0, x} * 24'd1311;
    return p[22:16];
  endfunction

  // floor(x/500) for x < 4700: x*8389 >> 22, exact over that range
  function automatic logic [3:0] div500(input logic [12:0] x);
    logic [26:0] p;
    p = {14'd0, x} * 27'd8389;
    return p[25:22];
  endfunction

  // min is checked first: with crossed limits, x below min gives min, else max
  function automatic logic [12:0] clamp13(input logic [12:0] x,
                                          input logic [11:0] lo,
                                          input logic [11:0] hi);
    logic [12:0] r;
    if (x < {1'b0, lo}) begin
      r = {1'b0, lo};
    end else if (x > {1'b0, hi}) begin
      r = {1'b0, hi};
    end else begin
      r = x;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/tad_chan_if.sv
interface tad_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/tad_decide.sv
module tad_decide (
  input  tad_pkg::in_item_t  item,
  input  tad_pkg::cfg_regs_t regs,
  output tad_pkg::out_item_t res
);
  import tad_pkg::*;

  logic [7:0]        tint;
  logic              invalid;
  logic              warmup;
  logic              too_soon;
  logic              low_reset;
  logic signed [9:0] diff;
  logic              in_band;
  logic              cool;
  logic [34:0]       rate_x5;
  logic [34:0]       tgt_x4;
  logic              rate_low;
  logic [12:0]       v_bump;
  logic              pwr_ok;
  logic [12:0]       f_ext;
  logic [12:0]       v_ext;
  logic [12:0]       f_up;
  logic [12:0]       f_dn;
  logic [12:0]       v_up;
  logic [12:0]       v_dn;
  logic [12:0]       f_cl;
  logic [12:0]       v_cl;

  assign tint      = item.die_temp[TempW-1:4];
  assign invalid   = (tint == TEMP_INVALID_INT) || (item.current_rate == '0);
  assign warmup    = (item.uptime < {16'd0, regs.warmup_seconds}) &&
                     (item.die_temp < {regs.target_temp, 4'd0});
  assign too_soon  = item.elapsed_ms <
                     ((item.die_temp < HOT_INTERVAL_Q) ? INTERVAL_COOL_MS : INTERVAL_HOT_MS);
  assign low_reset = item.low_rate_count >= regs.low_rate_limit;

  assign diff    = $signed({2'b00, tint}) - $signed({2'b00, regs.target_temp});
  assign in_band = (diff >= -BAND_HALF) && (diff <= BAND_HALF);
  assign cool    = diff < -BAND_HALF;

  assign rate_x5  = {1'b0, item.current_rate, 2'b00} + {3'd0, item.current_rate};
  assign tgt_x4   = {1'b0, item.target_rate, 2'b00};
  assign rate_low = rate_x5 < tgt_x4;
  assign v_bump   = {1'b0, item.volt_now} + VOLT_BUMP_MV;
  assign pwr_ok   = item.power_now < regs.power_cap;

  assign f_ext = {1'b0, item.freq_now};
  assign v_ext = {1'b0, item.volt_now};
  // +2% / -2% and +0.2% / -0.2%, floored; the down steps subtract a ceiling
  assign f_up  = f_ext + {6'd0, div50(f_ext)};
  assign f_dn  = f_ext - {6'd0, div50(f_ext + 13'd49)};
  assign v_up  = v_ext + {9'd0, div500(v_ext)};
  assign v_dn  = v_ext - {9'd0, div500(v_ext + 13'd499)};
  assign f_cl  = clamp13(cool ? f_up : f_dn, regs.freq_lo, regs.freq_hi);
  assign v_cl  = clamp13(cool ? v_up : v_dn, regs.volt_lo, regs.volt_hi);

  always_comb begin
    res.outcome     = OUT_NONE;
    res.freq_set    = '0;
    res.new_voltage = '0;
    if (invalid) begin
      res.outcome = OUT_INVALID;
    end else if (warmup) begin
      res.outcome = OUT_WARMUP;
    end else if (too_soon) begin
      res.outcome = OUT_TOO_SOON;
    end else if (low_reset) begin
      res.outcome = OUT_RESET;
    end else if (in_band) begin
      if (rate_low && (v_bump <= {1'b0, regs.volt_hi})) begin
        res.new_voltage = v_bump[VoltW-1:0];
        res.outcome     = OUT_ADJUST;
      end
    end else begin
      // cool steps need headroom and power below the cap; hot steps are not gated
      if ((!cool || ((item.freq_now < regs.freq_hi) && pwr_ok)) &&
          (f_cl != f_ext)) begin
        res.freq_set = f_cl[FreqW-1:0];
        res.outcome  = OUT_ADJUST;
      end
      if ((!cool || ((item.volt_now < regs.volt_hi) && pwr_ok)) &&
          (v_cl != v_ext)) begin
        res.new_voltage = v_cl[VoltW-1:0];
        res.outcome     = OUT_ADJUST;
      end
    end
  end

endmodule

>>> hw/rtl/thermal_autotune_decision.sv
// Thermal autotune decision block.
//
// Channels (valid/ready, a transaction completes when both are high):
//   in_ch  : one telemetry sample per transaction.
//   out_ch : one decision (outcome, freq_set, new_voltage) per sample,
//            in sample order.
//   cfg_ch : register writes (index, value); always ready. Write only while
//            no sample is in flight.
// Path: a sample taken on in_ch lands in the input register, is decided by
// one pass of combinational logic (tad_decide), loads the result register
// once that is empty or being drained, and is then offered on out_ch.
// Throughput: one sample per cycle while out_ch takes results; the input
// register and the result register form a two-deep pipeline, so a waiting
// result does not block intake until both stages are full.
// Reset (rst_n low, synchronous): pipeline empties, registers return to
// their defaults (target 60 C, 400..800 MHz, 1000..1400 mV, 40 W, 300 s, 3).
// Receiver stall: the result holds on out_ch; one more sample is still taken
// into an empty input register, after which in_ch.ready drops.
module thermal_autotune_decision (
  input logic        clk,
  input logic        rst_n,
  tad_chan_if.sink   in_ch,
  tad_chan_if.source out_ch,
  tad_chan_if.sink   cfg_ch
);
  import tad_pkg::*;

  cfg_regs_t regs_r;
  in_item_t  item_r;
  logic      s1_v_r;
  logic      s1_v_nxt;
  out_item_t res_r;
  out_item_t res_nxt;
  logic      out_v_r;
  logic      out_v_nxt;
  logic      in_acc;
  logic      out_load;
  cfg_wr_t   cfg_wr;

  // ---- configuration ----
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.target_temp    <= RST_TARGET_TEMP;
      regs_r.freq_hi        <= RST_FREQ_HI;
      regs_r.freq_lo        <= RST_FREQ_LO;
      regs_r.volt_hi        <= RST_VOLT_HI;
      regs_r.volt_lo        <= RST_VOLT_LO;
      regs_r.power_cap      <= RST_POWER_CAP;
      regs_r.warmup_seconds <= RST_WARMUP_SECONDS;
      regs_r.low_rate_limit <= RST_LOW_RATE_LIMIT;
    end else if (cfg_ch.valid) begin
      case (cfg_wr.index)
        CFG_TARGET_TEMP:    regs_r.target_temp    <= cfg_wr.value[7:0];
        CFG_FREQ_HI:        regs_r.freq_hi        <= cfg_wr.value[FreqW-1:0];
        CFG_FREQ_LO:        regs_r.freq_lo        <= cfg_wr.value[FreqW-1:0];
        CFG_VOLT_HI:        regs_r.volt_hi        <= cfg_wr.value[VoltW-1:0];
        CFG_VOLT_LO:        regs_r.volt_lo        <= cfg_wr.value[VoltW-1:0];
        CFG_POWER_CAP:      regs_r.power_cap      <= cfg_wr.value[PowerW-1:0];
        CFG_WARMUP_SECONDS: regs_r.warmup_seconds <= cfg_wr.value[15:0];
        CFG_LOW_RATE_LIMIT: regs_r.low_rate_limit <= cfg_wr.value[CountW-1:0];
        default: ;
      endcase
    end
  end

  // ---- pipeline control ----
  // result register loads from a full input stage when it is empty or being drained
  assign out_load    = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || !out_v_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (out_load) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (out_load) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_ch.data;
    end
    if (out_load) begin
      res_r <= res_nxt;
    end
  end

  // ---- decision ----
  tad_decide u_decide (
    .item (item_r),
    .regs (regs_r),
    .res  (res_nxt)
  );

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = res_r;

  // ---- checks ----
  // only an adjust reports new settings
  a_zero_unless_adjust: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (res_r.outcome != OUT_ADJUST)) |->
      ((res_r.freq_set == '0) && (res_r.new_voltage == '0)))
    else $error("nonzero setting without adjust outcome");

  // an accepted sample occupies the input stage next cycle
  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_v_r)
    else $error("accepted sample lost");

  // a sample in the input stage with an empty result register moves on
  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !out_v_r) |=> out_v_r)
    else $error("input stage did not advance");

endmodule

>>> dv/tb_thermal_autotune_decision.sv
module tb_thermal_autotune_decision;
  timeunit 1ns;
  timeprecision 1ps;
  import tad_pkg::*;

  // Holds the live register settings and the queue of expected decisions.
  class decision_scoreboard;
    cfg_regs_t regs;
    out_item_t pending_decisions[$];
    int        samples_seen;
    int        decisions_checked;
    int        errors;
    int        outcome_seen[8];

    function new();
      regs = '{RST_TARGET_TEMP, RST_FREQ_HI, RST_FREQ_LO, RST_VOLT_HI,
               RST_VOLT_LO, RST_POWER_CAP, RST_WARMUP_SECONDS, RST_LOW_RATE_LIMIT};
      samples_seen      = 0;
      decisions_checked = 0;
      errors            = 0;
      foreach (outcome_seen[i]) outcome_seen[i] = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_TARGET_TEMP:    regs.target_temp    = val[7:0];
        CFG_FREQ_HI:        regs.freq_hi        = val[FreqW-1:0];
        CFG_FREQ_LO:        regs.freq_lo        = val[FreqW-1:0];
        CFG_VOLT_HI:        regs.volt_hi        = val[VoltW-1:0];
        CFG_VOLT_LO:        regs.volt_lo        = val[VoltW-1:0];
        CFG_POWER_CAP:      regs.power_cap      = val[PowerW-1:0];
        CFG_WARMUP_SECONDS: regs.warmup_seconds = val[15:0];
        CFG_LOW_RATE_LIMIT: regs.low_rate_limit = val[CountW-1:0];
        default: ;
      endcase
    endfunction

    // exact floor(x * num / den); x is at most 12 bits so 32 bits suffice
    function logic [31:0] scaled_floor(logic [11:0] x, int unsigned num, int unsigned den);
      int unsigned prod;
      prod = x * num;
      return prod / den;
    endfunction

    // min limit is checked first: with crossed limits, x below min gives min, else max
    function logic [11:0] clamp_limits(logic [31:0] x, logic [11:0] lo, logic [11:0] hi);
      if (x < lo) return lo;
      if (x > hi) return hi;
      return x[11:0];
    endfunction

    function out_item_t predict_decision(in_item_t s);
      out_item_t        d;
      logic [7:0]       tint;
      logic [TimeW-1:0] interval;
      logic [63:0]      rate5;
      logic [63:0]      target4;
      logic [VoltW:0]   bumped;
      logic [FreqW-1:0] f_new;
      logic [VoltW-1:0] v_new;
      int               diff;
      d          = '0;
      d.outcome  = OUT_NONE;
      tint       = s.die_temp[TempW-1:4];
      diff       = int'(tint) - int'(regs.target_temp);
      interval   = (s.die_temp < HOT_INTERVAL_Q) ? INTERVAL_COOL_MS : INTERVAL_HOT_MS;
      rate5      = s.current_rate;
      rate5      = rate5 * 5;
      target4    = s.target_rate;
      target4    = target4 * 4;
      if (tint == TEMP_INVALID_INT || s.current_rate == '0) begin
        d.outcome = OUT_INVALID;
      end else if (s.uptime < regs.warmup_seconds && s.die_temp < {regs.target_temp, 4'h0}) begin
        d.outcome = OUT_WARMUP;
      end else if (s.elapsed_ms < interval) begin
        d.outcome = OUT_TOO_SOON;
      end else if (s.low_rate_count >= regs.low_rate_limit) begin
        d.outcome = OUT_RESET;
      end else if (diff >= -BAND_HALF && diff <= BAND_HALF) begin
        // near target: only a low hashrate gets a small voltage bump
        bumped = s.volt_now + VOLT_BUMP_MV;
        if (rate5 < target4 && bumped <= regs.volt_hi) begin
          d.new_voltage = bumped[VoltW-1:0];
          d.outcome     = OUT_ADJUST;
        end
      end else if (diff < -BAND_HALF) begin
        // cool: step up, gated by the power budget and the upper limits
        if (s.power_now < regs.power_cap) begin
          f_new = clamp_limits(scaled_floor(s.freq_now, 102, 100),
                               regs.freq_lo, regs.freq_hi);
          v_new = clamp_limits(scaled_floor(s.volt_now, 1002, 1000),
                               regs.volt_lo, regs.volt_hi);
          if (s.freq_now < regs.freq_hi && f_new != s.freq_now) begin
            d.freq_set = f_new;
            d.outcome  = OUT_ADJUST;
          end
          if (s.volt_now < regs.volt_hi && v_new != s.volt_now) begin
            d.new_voltage = v_new;
            d.outcome     = OUT_ADJUST;
          end
        end
      end else begin
        // hot: step down unconditionally
        f_new = clamp_limits(scaled_floor(s.freq_now, 98, 100),
                             regs.freq_lo, regs.freq_hi);
        v_new = clamp_limits(scaled_floor(s.volt_now, 998, 1000),
                             regs.volt_lo, regs.volt_hi);
        if (f_new != s.freq_now) begin
          d.freq_set = f_new;
          d.outcome  = OUT_ADJUST;
        end
        if (v_new != s.volt_now) begin
          d.new_voltage = v_new;
          d.outcome     = OUT_ADJUST;
        end
      end
      return d;
    endfunction

    function void note_sample(in_item_t s);
      samples_seen++;
      pending_decisions.push_back(predict_decision(s));
    endfunction

    function void check_decision(out_item_t got);
      out_item_t want;
      decisions_checked++;
      outcome_seen[got.outcome]++;
      if (pending_decisions.size() == 0) begin
        $error("decision with no sample outstanding: outcome %0d", got.outcome);
        errors++;
        return;
      end
      want = pending_decisions.pop_front();
      if (got.outcome !== want.outcome) begin
        $error("outcome: expected %0d, actual %0d", want.outcome, got.outcome);
        errors++;
      end
      if (got.freq_set !== want.freq_set) begin
        $error("freq_set: expected %0d, actual %0d", want.freq_set, got.freq_set);
        errors++;
      end
      if (got.new_voltage !== want.new_voltage) begin
        $error("new_voltage: expected %0d, actual %0d", want.new_voltage, got.new_voltage);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  // Throttle knobs, in percent of cycles spent idle on each side
  int send_idle_pct;
  int recv_idle_pct;
  int reg_writes;

  // Random samples per register setting; the extreme settings get fewer
  int phase_items[6] = '{100, 120, 40, 40, 80, 120};

  decision_scoreboard sb = new();

  tad_chan_if #(.payload_t(in_item_t))  in_if ();
  tad_chan_if #(.payload_t(out_item_t)) out_if ();
  tad_chan_if #(.payload_t(cfg_wr_t))   cfg_if ();

  thermal_autotune_decision dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    clk = 1'b0;
    #5ns;
    clk = 1'b1;
    #5ns;
  end

  // Uniform pick within [lo, hi], both trimmed to [0, top]
  function automatic int pick_near(int lo, int hi, int top);
    int a;
    int b;
    a = (lo < 0) ? 0 : lo;
    b = (hi > top) ? top : hi;
    if (a > b) a = b;
    return $urandom_range(b, a);
  endfunction

  // Random sample biased so most transactions get past the early checks and
  // land in the temperature bands, with boundary values mixed in.
  function automatic in_item_t shaped_sample(cfg_regs_t r);
    in_item_t         s;
    int               pick;
    int               t;
    int               lo;
    int               hi;
    int unsigned      base;
    logic [TimeW-1:0] interval;
    s = '0;

    // temperature: mostly within a few degrees of target
    pick = $urandom_range(99);
    if (pick < 4) begin
      s.die_temp = {TEMP_INVALID_INT, 4'($urandom)};
    end else if (pick < 12) begin
      s.die_temp = 12'($urandom);
    end else begin
      t = $urandom_range(12);
      t = t + int'(r.target_temp) - 6;
      if (t < 0) t = 0;
      if (t > 254) t = 254;
      s.die_temp = {8'(t), 4'($urandom)};
    end

    // hashrate: mostly a target with a measured rate 60..130% of it
    pick = $urandom_range(99);
    if (pick < 3) begin
      s.current_rate = '0;
      s.target_rate  = $urandom;
    end else if (pick < 18) begin
      s.current_rate = $urandom;
      s.target_rate  = $urandom;
    end else begin
      base           = $urandom_range(2_000_000, 1);
      s.target_rate  = base;
      s.current_rate = base / 100 * $urandom_range(130, 60);
    end

    pick = $urandom_range(99);
    if (pick < 15 && r.warmup_seconds != 0) begin
      s.uptime = $urandom_range(r.warmup_seconds - 1, 0);
    end else if (pick < 25) begin
      s.uptime = $urandom;
    end else begin
      s.uptime = r.warmup_seconds + $urandom_range(100000, 0);
    end

    interval = (s.die_temp < HOT_INTERVAL_Q) ? INTERVAL_COOL_MS : INTERVAL_HOT_MS;
    pick = $urandom_range(99);
    if (pick < 12) begin
      s.elapsed_ms = $urandom_range(interval - 1, 0);
    end else if (pick < 22) begin
      s.elapsed_ms = $urandom;
    end else begin
      s.elapsed_ms = interval + $urandom_range(1000, 0);
    end

    pick = $urandom_range(99);
    if (pick < 10) begin
      s.low_rate_count = 8'($urandom_range(255, r.low_rate_limit));
    end else if (pick < 15) begin
      s.low_rate_count = 8'($urandom);
    end else if (r.low_rate_limit != 0) begin
      s.low_rate_count = 8'($urandom_range(r.low_rate_limit - 1, 0));
    end

    // frequency: around the configured window, sometimes exactly at the top
    lo = (r.freq_lo < r.freq_hi) ? r.freq_lo : r.freq_hi;
    hi = (r.freq_lo < r.freq_hi) ? r.freq_hi : r.freq_lo;
    pick = $urandom_range(99);
    if (pick < 25) s.freq_now = 12'($urandom);
    else if (pick < 35) s.freq_now = r.freq_hi;
    else s.freq_now = 12'(pick_near(lo - 30, hi + 30, 4095));

    // voltage: same, plus the bump edge just under the top
    lo = (r.volt_lo < r.volt_hi) ? r.volt_lo : r.volt_hi;
    hi = (r.volt_lo < r.volt_hi) ? r.volt_hi : r.volt_lo;
    pick = $urandom_range(99);
    if (pick < 25) s.volt_now = 12'($urandom);
    else if (pick < 35) s.volt_now = r.volt_hi;
    else if (pick < 42) s.volt_now = r.volt_hi - 12'd10 + 12'($urandom_range(1));
    else s.volt_now = 12'(pick_near(lo - 30, hi + 30, 4095));

    pick = $urandom_range(99);
    if (pick < 25) s.power_now = 20'($urandom);
    else if (pick < 35) s.power_now = r.power_cap;
    else s.power_now = 20'(pick_near(int'(r.power_cap) - 3000, int'(r.power_cap) + 3000,
                                     20'hFFFFF));
    return s;
  endfunction

  // Hold a sample on the input channel until the transaction completes.
  // valid is only lowered while idling so back-to-back samples keep it high.
  task automatic send_sample(in_item_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= s;
    do @(posedge clk); while (!in_if.ready);
    sb.note_sample(s);
  endtask

  // Drop valid and wait until every outstanding decision has come back
  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending_decisions.size() != 0) @(posedge clk);
  endtask

  // Write all eight registers, one config transaction each
  task automatic load_settings(cfg_regs_t r);
    logic [CfgDataW-1:0] val;
    for (int i = 0; i < 8; i++) begin
      case (CfgIdxW'(i))
        CFG_TARGET_TEMP:    val = 20'(r.target_temp);
        CFG_FREQ_HI:        val = 20'(r.freq_hi);
        CFG_FREQ_LO:        val = 20'(r.freq_lo);
        CFG_VOLT_HI:        val = 20'(r.volt_hi);
        CFG_VOLT_LO:        val = 20'(r.volt_lo);
        CFG_POWER_CAP:      val = r.power_cap;
        CFG_WARMUP_SECONDS: val = 20'(r.warmup_seconds);
        CFG_LOW_RATE_LIMIT: val = 20'(r.low_rate_limit);
        default:            val = '0;
      endcase
      cfg_if.valid <= 1'b1;
      cfg_if.data  <= cfg_wr_t'{CfgIdxW'(i), val};
      do @(posedge clk); while (!cfg_if.ready);
      sb.write_reg(CfgIdxW'(i), val);
      reg_writes++;
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Result side: check on every completed transaction, then pick next ready.
  // Values read right after the edge are the ones sampled at that edge.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) sb.check_decision(out_if.data);
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    cfg_regs_t settings;
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.data    <= '0;
    cfg_if.valid  <= 1'b0;
    cfg_if.data   <= '0;
    send_idle_pct = 28;
    recv_idle_pct = 61;
    reg_writes    = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed samples against the reset settings (target 60 C, 400..800 MHz,
    // 1000..1400 mV, 40 W, 300 s warmup, limit 3).
    // Fields: temp, rate, target rate, uptime, freq, volt, power, low count, elapsed
    // invalid: integer part 255, and zero hashrate
    send_sample(in_item_t'{12'hFF0, 1000, 1000, 1000, 600, 1200, 20000, 0, 400000});
    send_sample(in_item_t'{12'hFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           12'hFFF, 12'hFFF, 20'hFFFFF, 8'hFF, 32'hFFFF_FFFF});
    send_sample(in_item_t'{960, 0, 1000, 1000, 600, 1200, 20000, 0, 400000});
    // warmup: fraction bits count; exactly at target is no longer cool
    send_sample(in_item_t'{959, 1000, 1000, 299, 600, 1200, 20000, 0, 400000});
    send_sample(in_item_t'{960, 1000, 1000, 299, 600, 1200, 20000, 0, 400000});
    send_sample(in_item_t'{0, 1, 0, 0, 0, 0, 0, 0, 0});
    // interval: just under 68 C uses the long one, 68 C the short one
    send_sample(in_item_t'{1087, 1000, 1000, 1000, 600, 1200, 20000, 0, 299999});
    send_sample(in_item_t'{1088, 1000, 1000, 1000, 600, 1200, 20000, 0, 499});
    // hot chip still in warmup window: warmup only applies below target
    send_sample(in_item_t'{1088, 1000, 1000, 0, 600, 1200, 20000, 0, 500});
    // low hashrate counter at the limit forces a preset reset
    send_sample(in_item_t'{960, 1000, 1000, 1000, 600, 1200, 20000, 3, 400000});
    // in band: low rate bumps voltage; 80% exactly is not low; zero target never low
    send_sample(in_item_t'{960, 799, 1000, 1000, 600, 1200, 20000, 0, 400000});
    send_sample(in_item_t'{960, 800, 1000, 1000, 600, 1200, 20000, 0, 400000});
    send_sample(in_item_t'{928, 1, 0, 1000, 600, 1200, 20000, 0, 400000});
    // bump lands exactly on the upper voltage limit, then one over
    send_sample(in_item_t'{992, 799, 1000, 1000, 600, 1390, 20000, 0, 400000});
    send_sample(in_item_t'{992, 799, 1000, 1000, 600, 1391, 20000, 0, 400000});
    // cool: normal step, clamp to max, already at max, clamp up to min, power gate
    send_sample(in_item_t'{912, 1000, 1000, 1000, 600, 1200, 20000, 0, 400000});
    send_sample(in_item_t'{800, 1000, 1000, 1000, 799, 1399, 39999, 0, 400000});
    send_sample(in_item_t'{800, 1000, 1000, 1000, 800, 1400, 20000, 0, 400000});
    send_sample(in_item_t'{800, 1000, 1000, 1000, 10, 10, 0, 0, 400000});
    send_sample(in_item_t'{800, 1000, 1000, 1000, 600, 1200, 40000, 0, 400000});
    // hot: step down pinned at min gives no change; huge values clamp to max
    send_sample(in_item_t'{1008, 1000, 1000, 1000, 400, 1000, 20000, 0, 400000});
    send_sample(in_item_t'{1008, 1000, 1000, 1000, 4095, 4095, 20'hFFFFF, 0, 400000});
    // all-ones fields just below the invalid temperature
    send_sample(in_item_t'{12'hFEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           12'hFFF, 12'hFFF, 20'hFFFFF, 8'hFF, 32'hFFFF_FFFF});
    send_sample(in_item_t'{12'hFEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           12'hFFF, 12'hFFF, 20'hFFFFF, 0, 32'hFFFF_FFFF});
    // coldest chip with zeroed settings fields gets raised to the minimums
    send_sample(in_item_t'{0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0, 0, 0, 0, 32'hFFFF_FFFF});
    drain();

    // Random phases, each under its own register setting. Registers are only
    // written once all decisions of the previous phase are back.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: settings = '{RST_TARGET_TEMP, RST_FREQ_HI, RST_FREQ_LO,
                        RST_VOLT_HI, RST_VOLT_LO, RST_POWER_CAP,
                        RST_WARMUP_SECONDS, RST_LOW_RATE_LIMIT};
        2: settings = '{8'hFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 20'hFFFFF, 16'hFFFF, 8'hFF};
        3: settings = '0;
        4: begin
          // crossed limits: min above max
          settings.target_temp    = 8'($urandom_range(100, 30));
          settings.freq_lo        = 12'($urandom_range(1500, 600));
          settings.freq_hi        = 12'($urandom_range(settings.freq_lo - 1, 100));
          settings.volt_lo        = 12'($urandom_range(1500, 1100));
          settings.volt_hi        = 12'($urandom_range(settings.volt_lo - 1, 700));
          settings.power_cap      = 20'($urandom_range(100000, 1000));
          settings.warmup_seconds = 16'($urandom_range(1000, 0));
          settings.low_rate_limit = 8'($urandom_range(20, 0));
        end
        default: begin
          settings.target_temp    = 8'($urandom_range(90, 40));
          settings.freq_lo        = 12'($urandom_range(600, 200));
          settings.freq_hi        = 12'($urandom_range(2000, settings.freq_lo));
          settings.volt_lo        = 12'($urandom_range(1100, 800));
          settings.volt_hi        = 12'($urandom_range(1500, settings.volt_lo));
          settings.power_cap      = 20'($urandom_range(100000, 1000));
          settings.warmup_seconds = 16'($urandom_range(600, 0));
          settings.low_rate_limit = 8'($urandom_range(10, 1));
        end
      endcase
      // throttle schedule: sender light / receiver heavy, then swapped, then none
      if (ph == 2) begin
        send_idle_pct = 61;
        recv_idle_pct = 28;
      end else if (ph == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_settings(settings);
      repeat (phase_items[ph]) send_sample(shaped_sample(sb.regs));
      drain();
    end

    // two-stage pipeline: idle on so that any stray decision is still caught
    repeat (8) @(posedge clk);
    $display("Covered %0d samples and %0d decisions over 6 register settings (%0d writes).",
             sb.samples_seen, sb.decisions_checked, reg_writes);
    $display("Outcome mix: none %0d, adjust %0d, invalid %0d, warmup %0d, early %0d, reset %0d",
             sb.outcome_seen[OUT_NONE], sb.outcome_seen[OUT_ADJUST],
             sb.outcome_seen[OUT_INVALID], sb.outcome_seen[OUT_WARMUP],
             sb.outcome_seen[OUT_TOO_SOON], sb.outcome_seen[OUT_RESET]);
    if (sb.errors == 0 && sb.pending_decisions.size() == 0) begin
      $display("tb_thermal_autotune_decision passed");
    end else begin
      $display("tb_thermal_autotune_decision failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2ms;
    $display("tb_thermal_autotune_decision failed");
    $finish;
  end

endmodule

>>> thermal_autotune_decision.f
hw/rtl/tad_pkg.sv
hw/rtl/tad_chan_if.sv
hw/rtl/tad_decide.sv
hw/rtl/thermal_autotune_decision.sv
dv/tb_thermal_autotune_decision.sv
